### sv/d2q9bgk_pkg.sv
// D2Q9 BGK collision core: shared constants, lattice tables, pipeline side-band type
// and small arithmetic helpers (saturation, per-direction projection, divide-by-nine digit).
// No dependencies.
package d2q9bgk_pkg;

  localparam int FRAC_BITS_DEF = 30;
  localparam int NDIR          = 9;
  localparam int CFG_IDX_W     = 1;

  localparam logic [30:0] RELAX_RST = 31'd1994325114;
  localparam logic [31:0] LID_RST   = 32'd107374182;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RELAX = 1'b0,
    CFG_LID   = 1'b1
  } cfg_idx_e;

  localparam int DIR_X [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  localparam int DIR_Y [NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
  localparam int WNUM  [NDIR] = '{16, 4, 4, 4, 4, 1, 1, 1, 1};

  localparam logic signed [127:0] SAT_HI = 128'sd2147483647;
  localparam logic signed [127:0] SAT_LO = -128'sd2147483648;

  typedef struct packed {
    logic             kind;
    logic             moving;
    logic [8:0][31:0] f;
    logic [31:0]      rho;
    logic [31:0]      ux;
    logic [31:0]      uy;
  } side_t;

  typedef struct packed {
    logic [7:0] q;
    logic [3:0] r;
  } d9_t;

  function automatic logic signed [31:0] sat32(input logic signed [127:0] v);
    logic signed [31:0] res;
    if (v > SAT_HI) begin
      res = 32'sh7fff_ffff;
    end else if (v < SAT_LO) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // saturated projection c[q].v
  function automatic logic signed [31:0] cv_sat(input int q, input logic signed [31:0] vx,
                                                input logic signed [31:0] vy);
    logic signed [33:0] sx;
    logic signed [33:0] sy;
    logic signed [33:0] s;
    case (DIR_X[q])
      1:       sx = 34'(vx);
      -1:      sx = -34'(vx);
      default: sx = '0;
    endcase
    case (DIR_Y[q])
      1:       sy = 34'(vy);
      -1:      sy = -34'(vy);
      default: sy = '0;
    endcase
    s = sx + sy;
    return sat32(128'(s));
  endfunction

  // one byte of long division by nine, remainder in and out
  function automatic d9_t div9_byte(input logic [3:0] r_in, input logic [7:0] b);
    logic [4:0] t;
    logic [3:0] r;
    d9_t        res;
    r = r_in;
    res = '0;
    for (int i = 7; i >= 0; i--) begin
      t = {r, b[i]};
      if (t >= 5'd9) begin
        res.q[i] = 1'b1;
        r = 4'(t - 5'd9);
      end else begin
        res.q[i] = 1'b0;
        r = t[3:0];
      end
    end
    res.r = r;
    return res;
  endfunction

endpackage

### sv/d2q9_bgk_collision_core.sv
// D2Q9 BGK collision core: fully pipelined per-cell collide / wall extrapolation.
// Depends on d2q9bgk_pkg.
//
//  port group     | direction | beat marked by      | payload
//  ---------------+-----------+---------------------+-------------------------------------
//  cell in        | in        | start_i & !busy_o   | kind_i, wall_moving_i, dist_0..8_i
//  result out     | out       | valid_o (one cycle) | post_0..8_o, density_out_o, vel_*_o
//  config write   | in        | cfg_we_i            | cfg_idx_i, cfg_data_i
//
// One cell enters per cycle; busy_o stays low. The delay from the accepting edge to the edge
// that takes the result is set by the 32-step bit-per-stage velocity divider and the
// byte-per-stage divide by nine in the equilibrium weights. Reset clears the valid pipe
// and loads the register defaults. The result side takes every beat, so nothing in the
// pipe ever waits.
module d2q9_bgk_collision_core #(
  parameter int FRAC_BITS = d2q9bgk_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                cfg_we_i,
  input  logic [d2q9bgk_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [31:0]                         cfg_data_i,
  input  logic                                kind_i,
  input  logic                                wall_moving_i,
  input  logic signed [31:0]                  dist_0_i,
  input  logic signed [31:0]                  dist_1_i,
  input  logic signed [31:0]                  dist_2_i,
  input  logic signed [31:0]                  dist_3_i,
  input  logic signed [31:0]                  dist_4_i,
  input  logic signed [31:0]                  dist_5_i,
  input  logic signed [31:0]                  dist_6_i,
  input  logic signed [31:0]                  dist_7_i,
  input  logic signed [31:0]                  dist_8_i,
  output logic                                valid_o,
  output logic signed [31:0]                  post_0_o,
  output logic signed [31:0]                  post_1_o,
  output logic signed [31:0]                  post_2_o,
  output logic signed [31:0]                  post_3_o,
  output logic signed [31:0]                  post_4_o,
  output logic signed [31:0]                  post_5_o,
  output logic signed [31:0]                  post_6_o,
  output logic signed [31:0]                  post_7_o,
  output logic signed [31:0]                  post_8_o,
  output logic signed [31:0]                  density_out_o,
  output logic signed [31:0]                  vel_x_out_o,
  output logic signed [31:0]                  vel_y_out_o
);
  import d2q9bgk_pkg::*;

  localparam int AW  = 35;
  localparam int DW  = 35;
  localparam int NW  = AW + FRAC_BITS;
  localparam int HW  = NW - 32;
  localparam int CW  = (HW > DW) ? HW : DW;
  localparam int TW  = 64 - FRAC_BITS;
  localparam int ZW  = TW + 2;
  localparam int ND  = (ZW + 7) / 8;
  localparam int YP  = 8 * ND;
  localparam int EW  = YP + 1;
  localparam int SW  = EW + 2;

  localparam int K_VEL = 34;
  localparam int K_E1  = 35;
  localparam int K_E2  = 36;
  localparam int K_E3  = 37;
  localparam int K_E4  = 38;
  localparam int K_E5  = 39;
  localparam int K_EQ  = K_E5 + ND + 1;
  localparam int K_C1  = K_EQ + 1;
  localparam int LAT   = K_C1 + 2;

  localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

  logic             accept;
  logic [8:0][31:0] dist_w;

  logic [30:0]        relax_q;
  logic signed [31:0] lid_q;

  logic [LAT-1:0] v_q;
  side_t          sd_q [LAT];
  side_t          sd_d [LAT];

  logic signed [35:0] rhow_q, rhow_d;
  logic signed [34:0] mx_q, mx_d, my_q, my_d;

  logic [DW-1:0]  dv_q   [33];
  logic [DW-1:0]  dv_d   [33];
  logic           pos_q  [33];
  logic           pos_d  [33];
  logic [DW-1:0]  rem_q  [2][33];
  logic [DW-1:0]  rem_d  [2][33];
  logic [31:0]    lo_q   [2][33];
  logic [31:0]    lo_d   [2][33];
  logic           neg_q  [2][33];
  logic           neg_d  [2][33];
  logic           ovf_q  [2][33];
  logic           ovf_d  [2][33];

  logic signed [31:0] ux_d, uy_d;

  logic signed [31:0]   cv_q   [2][9];
  logic signed [31:0]   cv_d   [2][9];
  logic signed [TW-1:0] sq_q   [3];
  logic signed [TW-1:0] sq_d   [3];
  logic signed [31:0]   cvb_q  [2][9];
  logic signed [TW-1:0] cv2_q  [2][9];
  logic signed [TW-1:0] cv2_d  [2][9];
  logic signed [TW:0]   vv_q   [2];
  logic signed [TW:0]   vv_d   [2];
  logic signed [31:0]   poly_q [2][9];
  logic signed [31:0]   poly_d [2][9];
  logic signed [TW-1:0] t_q    [2][9];
  logic signed [TW-1:0] t_d    [2][9];
  logic [YP-1:0]        w9_q   [2][9][ND+1];
  logic [YP-1:0]        w9_d   [2][9][ND+1];
  logic [3:0]           r9_q   [2][9][ND+1];
  logic [3:0]           r9_d   [2][9][ND+1];
  logic                 n9_q   [2][9][ND+1];
  logic                 n9_d   [2][9][ND+1];
  logic signed [EW-1:0] eq_q   [2][9];
  logic signed [EW-1:0] eq_d   [2][9];
  logic signed [63:0]   prod_q [9];
  logic signed [63:0]   prod_d [9];
  logic signed [SW-1:0] wsum_q [9];
  logic signed [SW-1:0] wsum_d [9];
  logic signed [31:0]   post_q [9];
  logic signed [31:0]   post_d [9];

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign dist_w[0] = dist_0_i;
  assign dist_w[1] = dist_1_i;
  assign dist_w[2] = dist_2_i;
  assign dist_w[3] = dist_3_i;
  assign dist_w[4] = dist_4_i;
  assign dist_w[5] = dist_5_i;
  assign dist_w[6] = dist_6_i;
  assign dist_w[7] = dist_7_i;
  assign dist_w[8] = dist_8_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relax_q <= RELAX_RST;
      lid_q   <= LID_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_RELAX: relax_q <= cfg_data_i[30:0];
        CFG_LID:   lid_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[LAT-2:0], accept};
    end
  end

  // stage 0: capture, density and momentum sums
  always_comb begin
    logic signed [35:0] s;
    logic signed [34:0] x;
    logic signed [34:0] y;
    s = '0;
    x = '0;
    y = '0;
    for (int q = 0; q < NDIR; q++) begin
      s = s + 36'($signed(dist_w[q]));
      if (DIR_X[q] == 1) x = x + 35'($signed(dist_w[q]));
      if (DIR_X[q] == -1) x = x - 35'($signed(dist_w[q]));
      if (DIR_Y[q] == 1) y = y + 35'($signed(dist_w[q]));
      if (DIR_Y[q] == -1) y = y - 35'($signed(dist_w[q]));
    end
    rhow_d = s;
    mx_d   = x;
    my_d   = y;
    sd_d[0].kind   = kind_i;
    sd_d[0].moving = wall_moving_i;
    sd_d[0].f      = dist_w;
    sd_d[0].rho    = sat32(128'(s));
    sd_d[0].ux     = '0;
    sd_d[0].uy     = '0;
    for (int k = 1; k < LAT; k++) begin
      sd_d[k] = sd_q[k-1];
    end
    sd_d[K_VEL].ux = ux_d;
    sd_d[K_VEL].uy = uy_d;
  end

  // velocity divider: setup, then one quotient bit per stage
  always_comb begin
    logic signed [34:0] m;
    logic [AW-1:0]      am;
    logic [NW-1:0]      nn;
    logic [HW-1:0]      hi;
    logic [DW:0]        t;
    logic               ge;
    dv_d[0]  = DW'(rhow_q);
    pos_d[0] = rhow_q > 36'sd0;
    for (int a = 0; a < 2; a++) begin
      m  = (a == 0) ? mx_q : my_q;
      am = m[34] ? AW'(-m) : AW'(m);
      nn = {am, {FRAC_BITS{1'b0}}};
      hi = nn[NW-1:32];
      neg_d[a][0] = m[34];
      ovf_d[a][0] = CW'(hi) >= CW'(DW'(rhow_q));
      rem_d[a][0] = ovf_d[a][0] ? '0 : DW'(hi);
      lo_d[a][0]  = nn[31:0];
    end
    for (int j = 1; j <= 32; j++) begin
      dv_d[j]  = dv_q[j-1];
      pos_d[j] = pos_q[j-1];
      for (int a = 0; a < 2; a++) begin
        t  = {rem_q[a][j-1], lo_q[a][j-1][31]};
        ge = t >= {1'b0, dv_q[j-1]};
        rem_d[a][j] = ge ? DW'(t - {1'b0, dv_q[j-1]}) : DW'(t);
        lo_d[a][j]  = {lo_q[a][j-1][30:0], ge};
        neg_d[a][j] = neg_q[a][j-1];
        ovf_d[a][j] = ovf_q[a][j-1];
      end
    end
  end

  always_comb begin
    logic signed [31:0] u [2];
    logic [31:0]        qv;
    for (int a = 0; a < 2; a++) begin
      qv = lo_q[a][32];
      if (!pos_q[32]) begin
        u[a] = '0;
      end else if (ovf_q[a][32] || qv[31]) begin
        u[a] = neg_q[a][32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
        u[a] = neg_q[a][32] ? -$signed({1'b0, qv[30:0]}) : $signed({1'b0, qv[30:0]});
      end
    end
    ux_d = u[0];
    uy_d = u[1];
  end

  // equilibria: projections and squares, then polynomial, density scaling, weights
  always_comb begin
    logic signed [31:0] ux;
    logic signed [31:0] uy;
    logic signed [31:0] wx;
    logic signed [63:0] p;
    logic signed [63:0] pl;
    logic signed [ZW-1:0] z;
    logic signed [ZW:0]   zz;
    logic signed [ZW:0]   yv;
    d9_t                  dr;
    ux = $signed(sd_q[K_VEL].ux);
    uy = $signed(sd_q[K_VEL].uy);
    wx = (sd_q[K_VEL].kind && sd_q[K_VEL].moving) ? lid_q : 32'sd0;
    p = 64'(ux) * 64'(ux);
    sq_d[0] = TW'(p >>> FRAC_BITS);
    p = 64'(uy) * 64'(uy);
    sq_d[1] = TW'(p >>> FRAC_BITS);
    p = 64'(wx) * 64'(wx);
    sq_d[2] = TW'(p >>> FRAC_BITS);
    vv_d[0] = (TW+1)'(sq_q[0]) + (TW+1)'(sq_q[1]);
    vv_d[1] = (TW+1)'(sq_q[2]);
    for (int q = 0; q < NDIR; q++) begin
      cv_d[0][q] = cv_sat(q, ux, uy);
      cv_d[1][q] = cv_sat(q, wx, 32'sd0);
      for (int m = 0; m < 2; m++) begin
        p = 64'(cv_q[m][q]) * 64'(cv_q[m][q]);
        cv2_d[m][q] = TW'(p >>> FRAC_BITS);
        pl = ONE + 64'sd3 * 64'(cvb_q[m][q]) + ((64'sd9 * 64'(cv2_q[m][q])) >>> 1)
             - ((64'sd3 * 64'(vv_q[m])) >>> 1);
        poly_d[m][q] = sat32(128'(pl));
        p = 64'($signed(sd_q[K_E3].rho)) * 64'(poly_q[m][q]);
        t_d[m][q] = TW'(p >>> FRAC_BITS);
        case (WNUM[q])
          16:      z = {t_q[m][q], 2'b00};
          4:       z = ZW'(t_q[m][q]);
          default: z = ZW'(t_q[m][q] >>> 2);
        endcase
        zz = (ZW+1)'(z);
        yv = z[ZW-1] ? (ZW+1)'(8) - zz : zz;
        w9_d[m][q][0] = YP'(yv[ZW-1:0]);
        r9_d[m][q][0] = '0;
        n9_d[m][q][0] = z[ZW-1];
        for (int j = 1; j <= ND; j++) begin
          dr = div9_byte(r9_q[m][q][j-1], w9_q[m][q][j-1][YP-1 -: 8]);
          w9_d[m][q][j] = {w9_q[m][q][j-1][YP-9:0], dr.q};
          r9_d[m][q][j] = dr.r;
          n9_d[m][q][j] = n9_q[m][q][j-1];
        end
        eq_d[m][q] = n9_q[m][q][ND] ? -$signed({1'b0, w9_q[m][q][ND]})
                                    : $signed({1'b0, w9_q[m][q][ND]});
      end
    end
  end

  // relaxation or ghost-cell extrapolation, final saturation
  always_comb begin
    logic signed [31:0]  f;
    logic signed [31:0]  diff;
    logic signed [127:0] rr;
    for (int q = 0; q < NDIR; q++) begin
      f = $signed(sd_q[K_EQ].f[q]);
      diff = sat32(128'(eq_q[0][q]) - 128'(f));
      prod_d[q] = 64'($signed({1'b0, relax_q})) * 64'(diff);
      wsum_d[q] = SW'(eq_q[1][q]) + SW'(f) - SW'(eq_q[0][q]);
      f = $signed(sd_q[K_C1].f[q]);
      if (sd_q[K_C1].kind) begin
        rr = 128'(wsum_q[q]);
      end else begin
        rr = 128'(f) + 128'(prod_q[q] >>> FRAC_BITS);
      end
      post_d[q] = sat32(rr);
    end
  end

  always_ff @(posedge clk_i) begin
    rhow_q <= rhow_d;
    mx_q   <= mx_d;
    my_q   <= my_d;
    for (int k = 0; k < LAT; k++) begin
      sd_q[k] <= sd_d[k];
    end
    for (int j = 0; j <= 32; j++) begin
      dv_q[j]  <= dv_d[j];
      pos_q[j] <= pos_d[j];
      for (int a = 0; a < 2; a++) begin
        rem_q[a][j] <= rem_d[a][j];
        lo_q[a][j]  <= lo_d[a][j];
        neg_q[a][j] <= neg_d[a][j];
        ovf_q[a][j] <= ovf_d[a][j];
      end
    end
    for (int i = 0; i < 3; i++) begin
      sq_q[i] <= sq_d[i];
    end
    for (int m = 0; m < 2; m++) begin
      vv_q[m] <= vv_d[m];
      for (int q = 0; q < NDIR; q++) begin
        cv_q[m][q]   <= cv_d[m][q];
        cvb_q[m][q]  <= cv_q[m][q];
        cv2_q[m][q]  <= cv2_d[m][q];
        poly_q[m][q] <= poly_d[m][q];
        t_q[m][q]    <= t_d[m][q];
        eq_q[m][q]   <= eq_d[m][q];
        for (int j = 0; j <= ND; j++) begin
          w9_q[m][q][j] <= w9_d[m][q][j];
          r9_q[m][q][j] <= r9_d[m][q][j];
          n9_q[m][q][j] <= n9_d[m][q][j];
        end
      end
    end
    for (int q = 0; q < NDIR; q++) begin
      prod_q[q] <= prod_d[q];
      wsum_q[q] <= wsum_d[q];
      post_q[q] <= post_d[q];
    end
  end

  assign valid_o       = v_q[LAT-1];
  assign post_0_o      = post_q[0];
  assign post_1_o      = post_q[1];
  assign post_2_o      = post_q[2];
  assign post_3_o      = post_q[3];
  assign post_4_o      = post_q[4];
  assign post_5_o      = post_q[5];
  assign post_6_o      = post_q[6];
  assign post_7_o      = post_q[7];
  assign post_8_o      = post_q[8];
  assign density_out_o = sd_q[LAT-1].rho;
  assign vel_x_out_o   = sd_q[LAT-1].ux;
  assign vel_y_out_o   = sd_q[LAT-1].uy;

  a_beat_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i, LAT))
    else $error("result beat without a matching input beat");

  a_zero_density_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (density_out_o <= 32'sd0) |-> (vel_x_out_o == 32'sd0) && (vel_y_out_o == 32'sd0))
    else $error("nonzero velocity with non-positive density");

  a_no_relax_passthru: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (relax_q == '0) && !$past(kind_i, LAT) |-> post_0_o == $past(dist_0_i, LAT))
    else $error("collide with zero rate changed the rest distribution");

endmodule

### tb/d2q9_bgk_collision_core_tb.sv
// Self-checking testbench for d2q9_bgk_collision_core: cells are driven through the start/busy
// handshake, and every valid_o beat is compared against an in-bench fixed-point BGK model.
// Depends on d2q9bgk_pkg and d2q9_bgk_collision_core.
module d2q9_bgk_collision_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import d2q9bgk_pkg::*;

  localparam int  FB        = 30;
  localparam int  SETTLE    = 60;
  localparam int  MAX_CYC   = 600000;
  localparam int  N_RANDOM  = 1650;

  typedef logic [8:0][31:0]  cell_t;
  typedef logic [11:0][31:0] post_t;

  logic clk_i, rst_ni, start_i, busy_o, cfg_we_i, valid_o;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic kind_i, wall_moving_i;
  logic signed [31:0] dist_i [9];
  logic signed [31:0] post_o [9];
  logic signed [31:0] density_out_o, vel_x_out_o, vel_y_out_o;

  logic [30:0] relax_rate;
  logic [31:0] lid_speed;
  post_t       pending_cells [$];
  int          mismatches, cells_sent, cells_checked, wall_cells, cycles;

  d2q9_bgk_collision_core DUT (
    .clk_i, .rst_ni, .start_i, .busy_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .kind_i, .wall_moving_i,
    .dist_0_i(dist_i[0]), .dist_1_i(dist_i[1]), .dist_2_i(dist_i[2]),
    .dist_3_i(dist_i[3]), .dist_4_i(dist_i[4]), .dist_5_i(dist_i[5]),
    .dist_6_i(dist_i[6]), .dist_7_i(dist_i[7]), .dist_8_i(dist_i[8]),
    .valid_o,
    .post_0_o(post_o[0]), .post_1_o(post_o[1]), .post_2_o(post_o[2]),
    .post_3_o(post_o[3]), .post_4_o(post_o[4]), .post_5_o(post_o[5]),
    .post_6_o(post_o[6]), .post_7_o(post_o[7]), .post_8_o(post_o[8]),
    .density_out_o, .vel_x_out_o, .vel_y_out_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------- fixed-point model ----------------
  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint p;
    p = clip32(a) * clip32(b);
    return p >>> FB;
  endfunction

  function automatic longint div_floor(longint x, longint d);
    if (x >= 0) return x / d;
    return -((-x + d - 1) / d);
  endfunction

  function automatic longint vel_of(longint m, longint rho);
    logic [127:0] num;
    logic [127:0] quo;
    longint       mag;
    if (rho <= 0) return 0;
    mag = (m < 0) ? -m : m;
    num = 128'(mag) << FB;
    quo = num / 128'(rho);
    if (quo >= 128'h1_0000_0000) quo = 128'h1_0000_0000;
    return clip32((m < 0) ? -longint'(quo) : longint'(quo));
  endfunction

  function automatic longint feq_of(int q, longint rho, longint vx, longint vy);
    longint cv, cv2, vv, poly, t;
    cv   = clip32(DIR_X[q] * vx + DIR_Y[q] * vy);
    cv2  = fx_mul(cv, cv);
    vv   = fx_mul(vx, vx) + fx_mul(vy, vy);
    poly = (64'sd1 <<< FB) + 3 * cv + div_floor(9 * cv2, 2) - div_floor(3 * vv, 2);
    t    = fx_mul(rho, poly);
    return div_floor(t * WNUM[q], 36);
  endfunction

  function automatic post_t collide_cell(logic kind, logic moving, cell_t c);
    longint f [9];
    longint rho_w, mx, my, rho, ux, uy, wx, eq, r;
    post_t  res;
    rho_w = 0; mx = 0; my = 0; wx = 0;
    for (int q = 0; q < 9; q++) begin
      f[q]  = longint'(signed'(c[q]));
      rho_w += f[q];
      mx    += DIR_X[q] * f[q];
      my    += DIR_Y[q] * f[q];
    end
    rho = clip32(rho_w);
    ux  = vel_of(mx, rho_w);
    uy  = vel_of(my, rho_w);
    if (kind && moving) wx = longint'(signed'(lid_speed));
    for (int q = 0; q < 9; q++) begin
      eq = feq_of(q, rho, ux, uy);
      if (kind) r = feq_of(q, rho, wx, 0) + f[q] - eq;
      else      r = f[q] + fx_mul(longint'(relax_rate), clip32(eq - f[q]));
      res[q] = 32'(clip32(r));
    end
    res[9]  = 32'(rho);
    res[10] = 32'(ux);
    res[11] = 32'(uy);
    return res;
  endfunction

  // ---------------- result checking ----------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= 20)
      $display("%0t mismatch cell %0d %s: got %h want %h", $realtime, cells_checked,
               what, got, want);
  endtask

  always @(posedge clk_i) begin
    post_t want;
    post_t got;
    if (rst_ni && valid_o) begin
      for (int q = 0; q < 9; q++) got[q] = post_o[q];
      got[9] = density_out_o; got[10] = vel_x_out_o; got[11] = vel_y_out_o;
      if (pending_cells.size() == 0) begin
        report_mismatch("unexpected beat", got[9], '0);
      end else begin
        want = pending_cells.pop_front();
        for (int k = 0; k < 12; k++)
          if (got[k] !== want[k])
            report_mismatch(k < 9 ? $sformatf("post_%0d", k) :
                            k == 9 ? "density" : k == 10 ? "vel_x" : "vel_y",
                            got[k], want[k]);
      end
      cells_checked++;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MAX_CYC) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------- drivers ----------------
  task automatic send_cell(logic kind, logic moving, cell_t c);
    kind_i        <= kind;
    wall_moving_i <= moving;
    for (int q = 0; q < 9; q++) dist_i[q] <= c[q];
    start_i       <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_cells.push_back(collide_cell(kind, moving, c));
    cells_sent++;
    if (kind) wall_cells++;
  endtask

  task automatic hold_off(int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic random_gap(bit gaps_on);
    int sel;
    sel = $urandom_range(99);
    if (!gaps_on || sel < 65) return;
    if (sel < 95) hold_off($urandom_range(3, 1));
    else          hold_off($urandom_range(40, 8));
  endtask

  task automatic drain();
    hold_off(1);
    while (pending_cells.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == CFG_RELAX) relax_rate = data[30:0];
    else                  lid_speed  = data;
  endtask

  // ---------------- cell generators ----------------
  function automatic logic [31:0] srand(int span);
    return 32'(int'($urandom_range(2 * span, 0)) - span);
  endfunction

  // near-equilibrium cell: density near one, small velocity, a little noise
  function automatic cell_t fluid_cell();
    longint rho, ux, uy, v;
    cell_t  c;
    rho = (64'sd1 <<< FB) + longint'(signed'(srand(1 << 28)));
    ux  = longint'(signed'(srand(1 << 27)));
    uy  = longint'(signed'(srand(1 << 27)));
    for (int q = 0; q < 9; q++) begin
      v = rho * WNUM[q] / 36 + (WNUM[q] * (DIR_X[q] * ux + DIR_Y[q] * uy)) / 12;
      c[q] = 32'(v + longint'(signed'(srand(1 << 22))));
    end
    return c;
  endfunction

  function automatic cell_t noise_cell();
    cell_t c;
    int    pick;
    for (int q = 0; q < 9; q++) begin
      pick = $urandom_range(9);
      if (pick == 0)      c[q] = 32'h7fff_ffff;
      else if (pick == 1) c[q] = 32'h8000_0000;
      else if (pick == 2) c[q] = 32'h0;
      else                c[q] = $urandom;
    end
    return c;
  endfunction

  // ---------------- tests ----------------
  task automatic test_directed();
    cell_t c;
    c = '0;
    send_cell(1'b0, 1'b0, c);
    send_cell(1'b1, 1'b1, c);
    c = {9{32'h7fff_ffff}};
    send_cell(1'b0, 1'b1, c);
    send_cell(1'b1, 1'b1, c);
    c = {9{32'h8000_0000}};
    send_cell(1'b0, 1'b0, c);
    send_cell(1'b1, 1'b0, c);
    for (int q = 0; q < 9; q++) c[q] = 32'((64'sd1 <<< FB) * WNUM[q] / 36);
    send_cell(1'b0, 1'b0, c);
    send_cell(1'b1, 1'b0, c);
    send_cell(1'b1, 1'b1, c);
    hold_off(2);
    // negative and zero density
    c = '0; c[0] = 32'hc000_0000; c[1] = 32'h1000_0000;
    send_cell(1'b0, 1'b0, c);
    c[0] = 32'hf000_0000;
    send_cell(1'b1, 1'b1, c);
    // tiny density, huge momentum: velocity saturation both signs
    c = '0; c[1] = 32'h4000_0000; c[3] = 32'hc000_0001; c[2] = 32'h7000_0000;
    c[4] = 32'h9000_0001;
    send_cell(1'b0, 1'b0, c);
    c[1] = 32'hc000_0001; c[3] = 32'h4000_0000;
    send_cell(1'b1, 1'b1, c);
    for (int q = 1; q < 9; q++) begin
      c = '0; c[0] = 32'h2000_0000; c[q] = 32'h4000_0000;
      send_cell(q[0], 1'b1, c);
    end
    drain();
  endtask

  task automatic test_random_phase(int n, bit gaps_on, bit pause_mid);
    logic kind;
    for (int i = 0; i < n; i++) begin
      kind = 1'($urandom_range(1));
      if ($urandom_range(99) < 80) send_cell(kind, 1'($urandom), fluid_cell());
      else                         send_cell(kind, 1'($urandom), noise_cell());
      random_gap(gaps_on);
      if (pause_mid && i == n / 2) begin
        hold_off(1);
        while (pending_cells.size() != 0) @(posedge clk_i);
      end
    end
    drain();
  endtask

  task automatic test_registers();
    int per;
    per = N_RANDOM / 6;
    test_random_phase(per, 1'b1, 1'b1);
    write_reg(CFG_RELAX, 32'h0);
    write_reg(CFG_LID, 32'h8000_0000);
    test_random_phase(per, 1'b1, 1'b0);
    write_reg(CFG_RELAX, 32'h7fff_ffff);
    write_reg(CFG_LID, 32'h7fff_ffff);
    test_random_phase(per, 1'b0, 1'b0);
    write_reg(CFG_RELAX, 32'h4000_0000);
    write_reg(CFG_LID, 32'h0);
    test_random_phase(per, 1'b1, 1'b0);
    for (int k = 0; k < 2; k++) begin
      write_reg(CFG_RELAX, {1'b0, 31'($urandom)});
      write_reg(CFG_LID, {$urandom} >> $urandom_range(8));
      test_random_phase(per, 1'b1, 1'b0);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0; cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    kind_i = 1'b0; wall_moving_i = 1'b0;
    for (int q = 0; q < 9; q++) dist_i[q] = '0;
    relax_rate = RELAX_RST;
    lid_speed  = LID_RST;
    mismatches = 0; cells_sent = 0; cells_checked = 0; wall_cells = 0; cycles = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_registers();
    $display("%0d cells sent (%0d wall), %0d beats checked, %0d mismatches",
             cells_sent, wall_cells, cells_checked, mismatches);
    $display("covered reset defaults and extreme relax/lid settings, with and without gaps");
    if (mismatches == 0 && pending_cells.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
sv/d2q9bgk_pkg.sv
sv/d2q9_bgk_collision_core.sv
tb/d2q9_bgk_collision_core_tb.sv
